// ===== src/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants for the logistic projection score block
// Request codes, register indexes, sigmoid table and the control struct.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned MAX_MARKERS_DEF = 256;
  localparam int unsigned MAX_EVECS_DEF   = 8;

  localparam logic [1:0] REQ_EIGEN  = 2'd0;
  localparam logic [1:0] REQ_BETA   = 2'd1;
  localparam logic [1:0] REQ_MARKER = 2'd2;

  localparam logic [1:0] REG_FREQ   = 2'd0;
  localparam logic [1:0] REG_LINKED = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam int unsigned ACC_W = 40;
  localparam int unsigned LOD_W = 64;

  typedef struct packed {
    logic       eig_wr;
    logic       beta_wr;
    logic       in_load;
    logic       mac_en;
    logic       acc_clr;
    logic       lod_init;
    logic       lod_en;
    logic       res_load;
    logic       use_freq;
  } lps_cmd_t;

  function automatic logic [15:0] sig_tab(input logic [4:0] idx);
    logic [15:0] r;
    begin
      case (idx)
        5'd0:  r = 16'd32768;
        5'd1:  r = 16'd40793;
        5'd2:  r = 16'd47911;
        5'd3:  r = 16'd53581;
        5'd4:  r = 16'd57724;
        5'd5:  r = 16'd60565;
        5'd6:  r = 16'd62428;
        5'd7:  r = 16'd63615;
        5'd8:  r = 16'd64357;
        5'd9:  r = 16'd64816;
        5'd10: r = 16'd65097;
        5'd11: r = 16'd65269;
        5'd12: r = 16'd65374;
        5'd13: r = 16'd65438;
        5'd14: r = 16'd65476;
        5'd15: r = 16'd65500;
        5'd16: r = 16'd65514;
        5'd17: r = 16'd65523;
        5'd18: r = 16'd65528;
        5'd19: r = 16'd65531;
        5'd20: r = 16'd65533;
        5'd21: r = 16'd65534;
        5'd22: r = 16'd65535;
        default: r = 16'd65535;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== src/lps_datapath.sv =====
// ----------------------------------------------------------------------------
// lps_datapath: tables, shared multiply-accumulate unit and sigmoid
// Holds eigen and beta memories, accumulators, the lod sum and the result.
// ----------------------------------------------------------------------------
module lps_datapath #(
  parameter int unsigned MAX_MARKERS = lps_pkg::MAX_MARKERS_DEF,
  parameter int unsigned MAX_EVECS   = lps_pkg::MAX_EVECS_DEF,
  localparam int unsigned MW = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1,
  localparam int unsigned VW = (MAX_EVECS > 1) ? $clog2(MAX_EVECS) : 1,
  localparam int unsigned BW = $clog2(MAX_EVECS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lps_pkg::lps_cmd_t cmd,
  input  logic [VW-1:0]    vidx,
  input  logic [7:0]       in_marker,
  input  logic [3:0]       in_coef,
  input  logic [15:0]      in_value,
  input  logic [15:0]      allele_freq,
  output logic [16:0]      res_data
);
  localparam int unsigned DEPTH = MAX_MARKERS * MAX_EVECS;
  localparam int unsigned AW = MW + VW;
  localparam logic signed [39:0] ACC_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] ACC_MIN = {1'b1, {39{1'b0}}};

  logic signed [15:0] eig_mem [DEPTH];
  logic signed [15:0] beta_mem [MAX_EVECS + 1];
  logic signed [39:0] acc_r [MAX_EVECS];

  logic signed [15:0] eig_rd_r, beta_rd_r, val_r;
  logic [VW-1:0]      v1_r, v2_r;
  logic               mac1_r, mac2_r, lod1_r;
  logic signed [31:0] prod_r;
  logic signed [63:0] lod_r;
  logic [16:0]        res_r;
  logic [MW-1:0]      mrow, mrow_r;
  logic [AW-1:0]      wr_addr, rd_addr;

  assign mrow    = in_marker[MW-1:0];
  assign wr_addr = {mrow, in_coef[VW-1:0]};
  assign rd_addr = {mrow_r, vidx};

  always_ff @(posedge clk) begin
    if (cmd.eig_wr) begin
      eig_mem[wr_addr] <= in_value;
    end
    eig_rd_r <= eig_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.beta_wr) begin
      beta_mem[in_coef[BW-1:0]] <= in_value;
    end
    if (cmd.lod_init) begin
      beta_rd_r <= beta_mem[0];
    end else begin
      beta_rd_r <= beta_mem[BW'({1'b0, vidx} + 1'b1)];
    end
  end

  // Stage 1 register: read data and marker value; stage 2: product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac1_r <= 1'b0;
      mac2_r <= 1'b0;
      lod1_r <= 1'b0;
    end else begin
      mac1_r <= cmd.mac_en;
      mac2_r <= mac1_r;
      lod1_r <= cmd.lod_en;
    end
    if (cmd.in_load) begin
      val_r  <= in_value;
      mrow_r <= mrow;
    end
    v1_r   <= vidx;
    v2_r   <= v1_r;
    prod_r <= val_r * eig_rd_r;
  end

  logic signed [40:0] sum_w;
  assign sum_w = 41'(acc_r[v2_r]) + 41'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.acc_clr) begin
      for (int i = 0; i < MAX_EVECS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (mac2_r) begin
      if (sum_w > 41'(ACC_MAX)) begin
        acc_r[v2_r] <= ACC_MAX;
      end else if (sum_w < 41'(ACC_MIN)) begin
        acc_r[v2_r] <= ACC_MIN;
      end else begin
        acc_r[v2_r] <= sum_w[39:0];
      end
    end
  end

  // lod_init loads beta0 scaled by 2^29; lod_en adds one beta*acc term.
  logic signed [39:0] acc_sel_r;
  logic               init1_r;
  logic signed [55:0] term;
  assign term = beta_rd_r * acc_sel_r;

  always_ff @(posedge clk) begin
    acc_sel_r <= acc_r[vidx];
    init1_r   <= cmd.lod_init;
    if (init1_r) begin
      lod_r <= 64'(beta_rd_r) <<< 29;
    end else if (lod1_r) begin
      lod_r <= lod_r + 64'(term);
    end
  end

  logic        neg_r;
  logic [63:0] mag_r;
  logic [4:0]  seg;
  logic [15:0] frac, t0, t1;
  logic [31:0] step;
  logic [16:0] p;

  always_ff @(posedge clk) begin
    neg_r <= lod_r[63];
    mag_r <= lod_r[63] ? (64'd0 - 64'(lod_r)) : 64'(lod_r);
  end

  assign seg  = mag_r[40:36];
  assign frac = mag_r[35:20];
  assign t0   = lps_pkg::sig_tab(seg);
  assign t1   = lps_pkg::sig_tab(5'(seg + 5'd1));
  assign step = 32'(t1 - t0) * 32'(frac);
  assign p    = 17'(t0) + 17'(step[31:16]);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (cmd.use_freq) begin
        res_r <= {1'b0, allele_freq};
      end else if (mag_r >= (64'd11 << 37)) begin
        res_r <= {1'b1, neg_r ? 16'd0 : 16'd65535};
      end else begin
        res_r <= {1'b0, neg_r ? 16'(17'd65536 - p) : p[15:0]};
      end
    end
  end

  assign res_data = res_r;
endmodule

// ===== src/lps_ctrl.sv =====
// ----------------------------------------------------------------------------
// lps_ctrl: sequencer for the logistic projection score block
// Decodes each input beat, steps the MAC and lod loops, hands off results.
// ----------------------------------------------------------------------------
module lps_ctrl #(
  parameter int unsigned MAX_MARKERS = lps_pkg::MAX_MARKERS_DEF,
  parameter int unsigned MAX_EVECS   = lps_pkg::MAX_EVECS_DEF,
  localparam int unsigned VW = (MAX_EVECS > 1) ? $clog2(MAX_EVECS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        req_type,
  input  logic [7:0]        marker_index,
  input  logic [3:0]        coef_index,
  input  logic              last,
  input  logic              linked_mode,
  input  logic [3:0]        evec_count,
  output lps_pkg::lps_cmd_t cmd,
  output logic [VW-1:0]     vidx,
  output logic              out_tvalid,
  input  logic              out_tready
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_DRN  = 3'd2;
  localparam logic [2:0] ST_LOD  = 3'd3;
  localparam logic [2:0] ST_LWT  = 3'd4;
  localparam logic [2:0] ST_RES  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [3:0]    n;
  logic          last_r, last_nxt, ovld_r, ovld_nxt, acc_in;
  logic [1:0]    drn_r, drn_nxt;
  logic          use_model;

  assign n = (32'(evec_count) > MAX_EVECS) ? 4'(MAX_EVECS) : evec_count;
  assign use_model = linked_mode && (n != 4'd0);
  assign in_tready = (state_r == ST_IDLE) && (!ovld_r || out_tready);
  assign acc_in    = in_tvalid && in_tready;
  assign vidx       = v_r;
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    last_nxt  = last_r;
    drn_nxt   = drn_r;
    ovld_nxt  = ovld_r && !out_tready;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        v_nxt = '0;
        if (acc_in) begin
          case (req_type)
            lps_pkg::REQ_EIGEN: begin
              cmd.eig_wr = (32'(marker_index) < MAX_MARKERS) &&
                           (32'(coef_index) < MAX_EVECS);
            end
            lps_pkg::REQ_BETA: begin
              cmd.beta_wr = (32'(coef_index) <= MAX_EVECS);
            end
            lps_pkg::REQ_MARKER: begin
              cmd.in_load = 1'b1;
              last_nxt    = last;
              if ((32'(marker_index) < MAX_MARKERS) && (n != 4'd0)) begin
                state_nxt = ST_MAC;
              end else begin
                drn_nxt   = 2'd0;
                state_nxt = ST_DRN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        if (32'(v_r) + 1 >= 32'(n)) begin
          drn_nxt   = 2'd0;
          state_nxt = ST_DRN;
        end else begin
          v_nxt = v_r + 1'b1;
        end
      end
      ST_DRN: begin
        drn_nxt = drn_r + 2'd1;
        v_nxt   = '0;
        if (drn_r == 2'd3) begin
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else if (use_model) begin
            cmd.lod_init = 1'b1;
            state_nxt    = ST_LOD;
          end else begin
            state_nxt = ST_RES;
          end
        end
      end
      ST_LOD: begin
        cmd.lod_en = 1'b1;
        if (32'(v_r) + 1 >= 32'(n)) begin
          drn_nxt   = 2'd0;
          state_nxt = ST_LWT;
        end else begin
          v_nxt = v_r + 1'b1;
        end
      end
      ST_LWT: begin
        drn_nxt = drn_r + 2'd1;
        if (drn_r == 2'd1) begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (!ovld_r || out_tready) begin
          cmd.res_load = 1'b1;
          cmd.use_freq = !use_model;
          cmd.acc_clr  = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v_r     <= '0;
      last_r  <= 1'b0;
      drn_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v_r     <= v_nxt;
      last_r  <= last_nxt;
      drn_r   <= drn_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!ovld_r || out_tready)) else $error("result overwrite");
  a_res_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> ovld_r) else $error("result lost");
  a_mac_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_en |-> 32'(v_r) < 32'(n)) else $error("mac index range");
`endif
endmodule

// ===== src/logistic_projection_score_top.sv =====
// ----------------------------------------------------------------------------
// logistic_projection_score_top: logistic regression on principal components
// Loads eigen and beta tables, scores haplotypes, returns a Q0.16 probability.
// ----------------------------------------------------------------------------
// Input beats carry req_type in tuser and marker_index, coef_index, value in
// tdata; tlast marks the final marker of a haplotype. Load beats are written
// to the tables as they are taken. A marker beat steps the single shared
// multiply-accumulate unit over the n eigenvectors in use and then drains its
// pipeline; with n zero or the row out of range it only drains. A last
// marker then sums the lod terms when the model is applied and loads the
// result once the result register is free; the result beat carries prob
// in tdata and saturated in tuser. One beat is in work at a time. The result
// register holds while the receiver stalls; the next input is taken only
// once the result register is free or being emptied. Reset clears control
// state, the accumulators and registers (linked_mode to 1); tables stay
// undefined until loaded. Registers sit on the APB port at 0, 4 and 8.
// ----------------------------------------------------------------------------
module logistic_projection_score_top #(
  parameter int unsigned MAX_MARKERS = lps_pkg::MAX_MARKERS_DEF,
  parameter int unsigned MAX_EVECS   = lps_pkg::MAX_EVECS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // marker_index[7:0], coef_index[11:8], value[27:12]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // prob[15:0]
  output logic        out_tuser,  // saturated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int unsigned VW = (MAX_EVECS > 1) ? $clog2(MAX_EVECS) : 1;

  logic [15:0] freq_r;
  logic        linked_r;
  logic [3:0]  count_r;
  logic        wr;
  logic [1:0]  ridx;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r   <= '0;
      linked_r <= 1'b1;
      count_r  <= '0;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        lps_pkg::REG_FREQ:   freq_r   <= cfg_pwdata[15:0];
        lps_pkg::REG_LINKED: linked_r <= cfg_pwdata[0];
        lps_pkg::REG_COUNT:  count_r  <= cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      lps_pkg::REG_FREQ:   cfg_prdata = {16'd0, freq_r};
      lps_pkg::REG_LINKED: cfg_prdata = {31'd0, linked_r};
      lps_pkg::REG_COUNT:  cfg_prdata = {28'd0, count_r};
      default:             cfg_prdata = '0;
    endcase
  end

  lps_pkg::lps_cmd_t cmd;
  logic [VW-1:0]     vidx;
  logic [16:0]       res;

  lps_ctrl #(.MAX_MARKERS(MAX_MARKERS), .MAX_EVECS(MAX_EVECS)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .req_type(in_tuser), .marker_index(in_tdata[7:0]),
    .coef_index(in_tdata[11:8]), .last(in_tlast),
    .linked_mode(linked_r), .evec_count(count_r),
    .cmd, .vidx, .out_tvalid, .out_tready
  );

  lps_datapath #(.MAX_MARKERS(MAX_MARKERS), .MAX_EVECS(MAX_EVECS)) u_dp (
    .clk, .rst_n, .cmd, .vidx,
    .in_marker(in_tdata[7:0]), .in_coef(in_tdata[11:8]),
    .in_value(in_tdata[27:12]), .allele_freq(freq_r), .res_data(res)
  );

  assign out_tdata = res[15:0];
  assign out_tuser = res[16];
endmodule

// ===== test/lps_score_checker.sv =====
// ----------------------------------------------------------------------------
// lps_score_checker: scoreboard for the logistic projection score block
// Watches register writes and input beats, predicts each haplotype score
// in fixed point, and compares every result beat in order.
// ----------------------------------------------------------------------------
module lps_score_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // marker_index[7:0], coef_index[11:8], value[27:12]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // prob[15:0]
  input  logic        out_tuser,  // saturated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          scores_pending
);

  typedef struct packed {
    logic [15:0] prob;
    logic        sat;
  } score_t;

  localparam logic [15:0] SIG_POINTS [0:22] = '{
    16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
    16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
    16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514, 16'd65523,
    16'd65528, 16'd65531, 16'd65533, 16'd65534, 16'd65535
  };
  localparam longint PROJ_MAX = (longint'(1) <<< 39) - 1;
  localparam longint PROJ_MIN = -(longint'(1) <<< 39);

  logic [15:0]        freq_q16;
  logic               linked_on;
  logic [3:0]         evec_used;
  logic signed [15:0] eigen_mem [0:2047];
  logic signed [15:0] beta_mem [0:8];
  longint             projection [0:7];
  score_t             expected_scores [$];

  assign scores_pending = expected_scores.size();

  function automatic score_t logistic_q16(input longint lod);
    logic [63:0] mag;
    logic [63:0] frac;
    logic [63:0] step;
    logic [63:0] p;
    int          seg;
    score_t      r;
    mag = (lod < 0) ? -lod : lod;
    if (mag >= (64'd11 << 37)) begin
      r.sat  = 1'b1;
      r.prob = (lod < 0) ? 16'd0 : 16'd65535;
    end else begin
      seg    = int'(mag >> 36);
      frac   = (mag >> 20) & 64'hFFFF;
      step   = 64'(SIG_POINTS[seg+1] - SIG_POINTS[seg]);
      p      = 64'(SIG_POINTS[seg]) + ((step * frac) >> 16);
      r.sat  = 1'b0;
      r.prob = (lod < 0) ? 16'(64'd65536 - p) : p[15:0];
    end
    return r;
  endfunction

  task automatic absorb_beat(input logic [1:0] req, input logic [31:0] data,
                             input logic last);
    logic [7:0]         row;
    logic [3:0]         col;
    logic signed [15:0] val;
    int                 n;
    longint             sum;
    longint             lod;
    score_t             r;
    row = data[7:0];
    col = data[11:8];
    val = data[27:12];
    n   = (evec_used > 4'd8) ? 8 : int'(evec_used);
    case (req)
      lps_pkg::REQ_EIGEN: begin
        if (col < 4'd8) eigen_mem[{row, col[2:0]}] = val;
      end
      lps_pkg::REQ_BETA: begin
        if (col <= 4'd8) beta_mem[col] = val;
      end
      lps_pkg::REQ_MARKER: begin
        for (int v = 0; v < n; v++) begin
          sum = projection[v] + longint'(val) * longint'(eigen_mem[{row, 3'(v)}]);
          if (sum > PROJ_MAX) sum = PROJ_MAX;
          if (sum < PROJ_MIN) sum = PROJ_MIN;
          projection[v] = sum;
        end
        if (last) begin
          if (linked_on && n > 0) begin
            lod = longint'(beta_mem[0]) <<< 29;
            for (int v = 0; v < n; v++) lod += longint'(beta_mem[v+1]) * projection[v];
            r = logistic_q16(lod);
          end else begin
            r.prob = freq_q16;
            r.sat  = 1'b0;
          end
          for (int v = 0; v < 8; v++) projection[v] = 0;
          expected_scores.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    score_t want;
    if (!rst_n) begin
      freq_q16   <= 16'd0;
      linked_on  <= 1'b1;
      evec_used  <= 4'd0;
      fail_count <= 0;
      for (int v = 0; v < 8; v++) projection[v] = 0;
      expected_scores.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_scores.size() == 0) begin
          if (fail_count < 10)
            $display("Unexpected result beat: prob %0d sat %0d", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_scores.pop_front();
          if (want.prob !== out_tdata || want.sat !== out_tuser) begin
            if (fail_count < 10)
              $display("Score mismatch: expected prob %0d sat %0d, got prob %0d sat %0d",
                       want.prob, want.sat, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) absorb_beat(in_tuser, in_tdata, in_tlast);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          lps_pkg::REG_FREQ:   freq_q16  <= cfg_pwdata[15:0];
          lps_pkg::REG_LINKED: linked_on <= cfg_pwdata[0];
          lps_pkg::REG_COUNT:  evec_used <= cfg_pwdata[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/tb_logistic_projection_score_top.sv =====
// ----------------------------------------------------------------------------
// tb_logistic_projection_score_top: testbench for the logistic projection score
// Loads eigen and beta tables, streams haplotypes in random bursts under
// several register settings and receiver stalls, and checks every score.
// ----------------------------------------------------------------------------
module tb_logistic_projection_score_top;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;  // marker_index[7:0], coef_index[11:8], value[27:12]
  logic [1:0]  in_tuser = '0;  // req_type[1:0]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;      // prob[15:0]
  logic        out_tuser;      // saturated
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          scores_pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  logic [7:0]  row_cols [0:255];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logistic_projection_score_top dut (.*);

  lps_score_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (cycle_count % 5 == 0);
    endcase
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] req, input logic [7:0] row,
                           input logic [3:0] col, input logic [15:0] val,
                           input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'd0, val, col, row};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req == lps_pkg::REQ_EIGEN && col < 4'd8) row_cols[row][col[2:0]] = 1'b1;
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (scores_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    wait_quiet();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] loaded_row();
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255)); while (row_cols[r] != 8'hFF);
    return r;
  endfunction

  task automatic load_betas(input int scale);
    for (int b = 0; b <= 8; b++)
      send_beat(lps_pkg::REQ_BETA, 8'($urandom), 4'(b),
                16'($signed($urandom_range(0, 2 * (1 << scale))) - (1 << scale)),
                1'($urandom));
  endtask

  task automatic haplotype(input int len, input bit full_range);
    logic [15:0] val;
    for (int k = 0; k < len; k++) begin
      val = full_range ? 16'($urandom) : 16'($urandom_range(0, 32767));
      send_beat(lps_pkg::REQ_MARKER, loaded_row(), 4'($urandom), val, k == len - 1);
    end
  endtask

  initial begin
    int pick;
    for (int r = 0; r < 256; r++) row_cols[r] = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(lps_pkg::REG_FREQ, 32'hFFFF_FFFF);
    write_reg(lps_pkg::REG_LINKED, 32'h0000_0001);
    write_reg(lps_pkg::REG_COUNT, {28'hFFFFFFF, 4'd8});
    load_betas(6);
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 8; c++)
        send_beat(lps_pkg::REQ_EIGEN, 8'(r), 4'(c), 16'($urandom), 1'b0);
    for (int c = 0; c < 8; c++) begin
      send_beat(lps_pkg::REQ_EIGEN, 8'd254, 4'(c), 16'h7FFF, 1'b1);
      send_beat(lps_pkg::REQ_EIGEN, 8'd255, 4'(c), 16'h8000, 1'b0);
    end

    send_beat(lps_pkg::REQ_EIGEN, 8'd3, 4'd8, 16'h1234, 1'b0);
    send_beat(lps_pkg::REQ_EIGEN, 8'd3, 4'd15, 16'hFFFF, 1'b0);
    send_beat(lps_pkg::REQ_BETA, 8'd0, 4'd9, 16'h7FFF, 1'b0);
    send_beat(lps_pkg::REQ_BETA, 8'd0, 4'd15, 16'h8000, 1'b1);
    send_beat(REQ_UNUSED, 8'd0, 4'd0, 16'h0000, 1'b1);
    send_beat(lps_pkg::REQ_MARKER, 8'd0, 4'd0, 16'h7FFF, 1'b1);
    send_beat(lps_pkg::REQ_MARKER, 8'd255, 4'd0, 16'h8000, 1'b1);
    send_beat(lps_pkg::REQ_MARKER, 8'd254, 4'd0, 16'h0000, 1'b1);
    send_beat(lps_pkg::REQ_MARKER, 8'd1, 4'd0, 16'h4000, 1'b0);
    send_beat(lps_pkg::REQ_MARKER, 8'd2, 4'd0, 16'hFFFF, 1'b1);
    for (int k = 0; k < 520; k++)
      send_beat(lps_pkg::REQ_MARKER, 8'd255, 4'd0, 16'h8000, k == 519);
    for (int k = 0; k < 520; k++)
      send_beat(lps_pkg::REQ_MARKER, 8'd255, 4'd0, 16'h7FFF, k == 519);
    write_reg(lps_pkg::REG_COUNT, 32'd0);
    haplotype(2, 1'b1);
    write_reg(lps_pkg::REG_COUNT, 32'd15);
    write_reg(lps_pkg::REG_LINKED, 32'hFFFF_FFFE);
    haplotype(2, 1'b0);
    write_reg(lps_pkg::REG_FREQ, 32'd0);
    haplotype(1, 1'b0);

    for (int phase = 0; phase < 12; phase++) begin
      write_reg(lps_pkg::REG_FREQ, (phase % 4 == 0) ? 32'h0000_FFFF : $urandom);
      write_reg(lps_pkg::REG_LINKED, (phase % 5 == 4) ? 32'd0 : {31'($urandom), 1'b1});
      write_reg(lps_pkg::REG_COUNT,
                (phase % 3 == 0) ? 32'd8 : 32'($urandom_range(0, 15)));
      load_betas($urandom_range(0, 14));
      for (int n = 0; n < 52; ) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          pick = $urandom_range(1, 6);
          haplotype(pick, $urandom_range(0, 3) == 0);
          n += pick;
        end else begin
          case ($urandom_range(0, 2))
            0: send_beat(lps_pkg::REQ_EIGEN, 8'($urandom), 4'($urandom), 16'($urandom),
                         1'($urandom));
            1: send_beat(lps_pkg::REQ_BETA, 8'($urandom), 4'($urandom_range(0, 15)),
                         16'($signed($urandom_range(0, 256)) - 128), 1'($urandom));
            default: send_beat(REQ_UNUSED, 8'($urandom), 4'($urandom), 16'($urandom),
                               1'($urandom));
          endcase
          n++;
        end
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && scores_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lps_pkg.sv
src/lps_datapath.sv
src/lps_ctrl.sv
src/logistic_projection_score_top.sv
test/lps_score_checker.sv
test/tb_logistic_projection_score_top.sv
